>>> sv/sqlpc_pkg.sv
// sqlpc_pkg: shared constants, codes and transfer types of the packet classifier
// no dependencies; used by every other file of the block but sqlpc_in_if
`timescale 1ns / 1ps

package sqlpc_pkg;

	// header layout
	localparam int HEADER_BYTES = 4;
	localparam int USER_SKIP    = 9;
	localparam int POS_W        = 24;
	localparam int LEN_W        = 24;
	localparam int TOTAL_W      = 32;

	// defaults for the top level parameters
	localparam int USER_LEN_DEFAULT    = 30;
	localparam int COUNT_WIDTH_DEFAULT = 32;

	// command codes
	localparam logic [7:0] CMD_QUERY_LO  = 8'd3;
	localparam logic [7:0] CMD_QUERY_HI  = 8'd4;
	localparam logic [7:0] CMD_LOGIN     = 8'd5;
	localparam logic [7:0] CMD_LOGIN_EXT = 8'd133;

	// verdict codes
	typedef enum logic [2:0] {
		CLS_SHORT     = 3'd0,
		CLS_TRUNCATED = 3'd1,
		CLS_QUERY     = 3'd2,
		CLS_LOGIN     = 3'd3,
		CLS_BOGUS     = 3'd4
	} class_t;

	// one accepted input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	// one result
	typedef struct packed {
		logic               byte_valid;
		logic [7:0]         byte_out;
		logic               byte_is_user;
		logic               packet_done;
		class_t             packet_class;
		logic               user_found;
		logic [7:0]         sequence_number;
		logic [TOTAL_W-1:0] query_total;
		logic [TOTAL_W-1:0] bogus_total;
	} result_t;

	function automatic logic is_query(input logic [7:0] cmd);
		return (cmd == CMD_QUERY_LO) || (cmd == CMD_QUERY_HI);
	endfunction

	function automatic logic is_login(input logic [7:0] cmd);
		return (cmd == CMD_LOGIN) || (cmd == CMD_LOGIN_EXT);
	endfunction

endpackage

>>> sv/sqlpc_in_if.sv
// sqlpc_in_if: valid/ready channel carrying one packet byte and its last flag
// no dependencies
`timescale 1ns / 1ps

interface sqlpc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/sqlpc_out_if.sv
// sqlpc_out_if: valid/ready channel carrying one classifier result
// depends on sqlpc_pkg for the total width
`timescale 1ns / 1ps

interface sqlpc_out_if;
	logic                          valid;
	logic                          ready;
	logic                          byte_valid;
	logic [7:0]                    byte_out;
	logic                          byte_is_user;
	logic                          packet_done;
	logic [2:0]                    packet_class;
	logic                          user_found;
	logic [7:0]                    sequence_number;
	logic [sqlpc_pkg::TOTAL_W-1:0] query_total;
	logic [sqlpc_pkg::TOTAL_W-1:0] bogus_total;

	modport source (
		output valid, output byte_valid, output byte_out, output byte_is_user,
		output packet_done, output packet_class, output user_found,
		output sequence_number, output query_total, output bogus_total,
		input ready
	);
	modport sink (
		input valid, input byte_valid, input byte_out, input byte_is_user,
		input packet_done, input packet_class, input user_found,
		input sequence_number, input query_total, input bogus_total,
		output ready
	);
endinterface

>>> sv/sqlpc_in_stage.sv
// sqlpc_in_stage: input register of the classifier, one byte deep
// depends on sqlpc_pkg and sqlpc_in_if
`timescale 1ns / 1ps

module sqlpc_in_stage (
	input  logic             clk,
	input  logic             arst_n,
	sqlpc_in_if.sink         packet,
	input  logic             advance,
	output logic             item_valid,
	output sqlpc_pkg::item_t item
);

	logic             valid_s1;
	sqlpc_pkg::item_t item_s1;
	logic             take;

	// accept when empty or when the held byte moves on this cycle
	assign packet.ready = !valid_s1 || advance;
	assign take         = packet.valid && packet.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte <= packet.data_byte;
			item_s1.last_byte <= packet.last_byte;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

>>> sv/sqlpc_parse.sv
// sqlpc_parse: header tracking, byte pass-through decision, verdict and counters
// depends on sqlpc_pkg
`timescale 1ns / 1ps

module sqlpc_parse #(
	parameter int USER_LEN    = sqlpc_pkg::USER_LEN_DEFAULT,
	parameter int COUNT_WIDTH = sqlpc_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  sqlpc_pkg::item_t   item,
	output sqlpc_pkg::result_t result
);

	localparam int POS_W   = sqlpc_pkg::POS_W;
	localparam int LEN_W   = sqlpc_pkg::LEN_W;
	localparam int TOTAL_W = sqlpc_pkg::TOTAL_W;
	localparam int USER_LO = sqlpc_pkg::HEADER_BYTES + sqlpc_pkg::USER_SKIP;
	localparam int USER_HI = USER_LO + USER_LEN;

	logic [POS_W-1:0]       pos_q;
	logic [LEN_W-1:0]       len_q;
	logic [7:0]             cmd_q;
	logic [7:0]             seq_q;
	logic [COUNT_WIDTH-1:0] qcnt_q;
	logic [COUNT_WIDTH-1:0] bcnt_q;

	logic [POS_W-1:0]       pos_n;
	logic [LEN_W-1:0]       len_n;
	logic [7:0]             cmd_n;
	logic [7:0]             seq_n;
	logic [COUNT_WIDTH-1:0] qcnt_n;
	logic [COUNT_WIDTH-1:0] bcnt_n;

	logic                   in_header;
	logic                   user_window;
	logic                   long_login;
	logic [LEN_W+1:0]       seen;
	logic [LEN_W+1:0]       needed;
	logic [TOTAL_W-1:0]     qtot;
	logic [TOTAL_W-1:0]     btot;

	// header capture, byte pass-through and verdict
	always_comb begin
		pos_n  = pos_q;
		len_n  = len_q;
		cmd_n  = cmd_q;
		seq_n  = seq_q;
		qcnt_n = qcnt_q;
		bcnt_n = bcnt_q;
		result = '0;

		in_header = 1'b1;
		if (pos_q == POS_W'(0)) begin
			len_n = {{(LEN_W-8){1'b0}}, item.data_byte};
			cmd_n = '0;
			seq_n = '0;
		end else if (pos_q == POS_W'(1)) begin
			len_n[15:8] = item.data_byte;
		end else if (pos_q == POS_W'(2)) begin
			len_n[23:16] = item.data_byte;
		end else if (pos_q == POS_W'(sqlpc_pkg::HEADER_BYTES - 1)) begin
			seq_n = item.data_byte;
		end else if (pos_q == POS_W'(sqlpc_pkg::HEADER_BYTES)) begin
			cmd_n = item.data_byte;
		end else begin
			in_header = 1'b0;
		end

		// payload bytes: query body or username slice
		user_window = (pos_q >= POS_W'(USER_LO)) && (pos_q < POS_W'(USER_HI));
		long_login  = len_q > LEN_W'(USER_LEN);
		if (!in_header) begin
			if (sqlpc_pkg::is_query(cmd_q)) begin
				result.byte_valid = 1'b1;
				result.byte_out   = item.data_byte;
			end else if (sqlpc_pkg::is_login(cmd_q) && long_login && user_window) begin
				result.byte_valid   = 1'b1;
				result.byte_out     = item.data_byte;
				result.byte_is_user = 1'b1;
			end
		end

		// verdict on the last byte
		seen   = {2'b00, pos_q} + (LEN_W+2)'(1);
		needed = {2'b00, len_n} + (LEN_W+2)'(sqlpc_pkg::HEADER_BYTES);
		result.packet_class = sqlpc_pkg::CLS_SHORT;
		if (item.last_byte) begin
			result.packet_done = 1'b1;
			if (seen < (LEN_W+2)'(sqlpc_pkg::HEADER_BYTES)) begin
				result.packet_class = sqlpc_pkg::CLS_SHORT;
			end else if (seen < needed) begin
				result.packet_class = sqlpc_pkg::CLS_TRUNCATED;
			end else if (sqlpc_pkg::is_query(cmd_n)) begin
				result.packet_class = sqlpc_pkg::CLS_QUERY;
				qcnt_n = qcnt_q + COUNT_WIDTH'(1);
			end else if (sqlpc_pkg::is_login(cmd_n)) begin
				result.packet_class = sqlpc_pkg::CLS_LOGIN;
				result.user_found   = len_n > LEN_W'(USER_LEN);
			end else begin
				result.packet_class = sqlpc_pkg::CLS_BOGUS;
				bcnt_n = bcnt_q + COUNT_WIDTH'(1);
			end
			pos_n = '0;
		end else if (pos_q != {POS_W{1'b1}}) begin
			pos_n = pos_q + POS_W'(1);
		end

		result.sequence_number = seq_n;
		result.query_total     = qtot;
		result.bogus_total     = btot;
	end

	// fit the counters to the reported total width
	generate
		if (COUNT_WIDTH >= TOTAL_W) begin : g_tot_trunc
			assign qtot = qcnt_n[TOTAL_W-1:0];
			assign btot = bcnt_n[TOTAL_W-1:0];
		end else begin : g_tot_ext
			assign qtot = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, qcnt_n};
			assign btot = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, bcnt_n};
		end
	endgenerate

	// packet state, updated as each byte leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			cmd_q  <= '0;
			seq_q  <= '0;
			qcnt_q <= '0;
			bcnt_q <= '0;
		end else if (fire) begin
			pos_q  <= pos_n;
			len_q  <= len_n;
			cmd_q  <= cmd_n;
			seq_q  <= seq_n;
			qcnt_q <= qcnt_n;
			bcnt_q <= bcnt_n;
		end
	end

endmodule

>>> sv/sqlpc_out_stage.sv
// sqlpc_out_stage: result register driving the output channel
// depends on sqlpc_pkg and sqlpc_out_if
`timescale 1ns / 1ps

module sqlpc_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  sqlpc_pkg::result_t result,
	output logic               load,
	sqlpc_out_if.source        verdict
);

	logic               valid_s2;
	sqlpc_pkg::result_t result_s2;

	// load a waiting item whenever the register is empty or its result is taken now
	assign load = item_valid && (!valid_s2 || verdict.ready);

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (verdict.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			result_s2 <= result;
		end
	end

	assign verdict.valid           = valid_s2;
	assign verdict.byte_valid      = result_s2.byte_valid;
	assign verdict.byte_out        = result_s2.byte_out;
	assign verdict.byte_is_user    = result_s2.byte_is_user;
	assign verdict.packet_done     = result_s2.packet_done;
	assign verdict.packet_class    = result_s2.packet_class;
	assign verdict.user_found      = result_s2.user_found;
	assign verdict.sequence_number = result_s2.sequence_number;
	assign verdict.query_total     = result_s2.query_total;
	assign verdict.bogus_total     = result_s2.bogus_total;

endmodule

>>> sv/sql_packet_classifier.sv
// sql_packet_classifier: top level of the client packet header classifier
// depends on sqlpc_pkg, sqlpc_in_if, sqlpc_out_if and the three sqlpc stages
//
//  channel  | dir | payload                                          | transfer
//  ---------+-----+--------------------------------------------------+---------------------
//  packet   | in  | data_byte, last_byte                             | valid & ready
//  verdict  | out | byte_valid .. packet_class .. bogus_total        | valid & ready
//
// one byte per cycle sustained while verdict is ready; a result is offered once its byte
// has moved from the input register into the result register, and it is held there until taken
// each byte is decided by one compare-and-add stage between the two registers
// arst_n clears occupancy, packet position, header fields and both counters
// a stalled verdict holds one result while one more byte waits in the input register
`timescale 1ns / 1ps

module sql_packet_classifier #(
	parameter int USER_LEN    = sqlpc_pkg::USER_LEN_DEFAULT,
	parameter int COUNT_WIDTH = sqlpc_pkg::COUNT_WIDTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	sqlpc_in_if.sink    packet,
	sqlpc_out_if.source verdict
);

	logic               item_valid;
	sqlpc_pkg::item_t   item;
	sqlpc_pkg::result_t result;
	logic               load;

	// input register
	sqlpc_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.packet     (packet),
		.advance    (load),
		.item_valid (item_valid),
		.item       (item)
	);

	// parsing and classification
	sqlpc_parse #(
		.USER_LEN    (USER_LEN),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (load),
		.item   (item),
		.result (result)
	);

	// result register
	sqlpc_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.result     (result),
		.load       (load),
		.verdict    (verdict)
	);

endmodule
